FILE: rtl/core/lbps_pkg.sv
// ----------------------------------------------------------------------------
// lbps_pkg: shared types and constants of the LED blink and pulse sequencer
// Command codes, payload structs, register indexes, controller and phase
// state encodings, and the brightness scaling function.
// ----------------------------------------------------------------------------
package lbps_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int CFG_W           = 24;
	localparam int CFG_IDX_W       = 3;
	localparam int PENDING_W       = 5;

	// Register reset values.
	localparam logic [7:0]  BRIGHTNESS_RST   = 8'd24;
	localparam logic [15:0] HB_ON_TIME_RST   = 16'd140;
	localparam logic [15:0] HB_OFF_TIME_RST  = 16'd60;
	localparam logic [23:0] HB_PERIOD_RST    = 24'd300000;
	localparam logic        COLOR_MODE_RST   = 1'b0;

	// Heartbeat colors: blue-cyan for media mode, magenta for devices mode.
	localparam logic [23:0] HB_COLOR_MEDIA   = {8'd0, 8'd80, 8'd255};
	localparam logic [23:0] HB_COLOR_DEVICES = {8'd255, 8'd0, 8'd110};

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_PULSE = 2'd1,
		CMD_BLINK = 2'd2,
		CMD_OFF   = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BRIGHTNESS  = 3'd0,
		REG_HB_ON_TIME  = 3'd1,
		REG_HB_OFF_TIME = 3'd2,
		REG_HB_PERIOD   = 3'd3,
		REG_COLOR_MODE  = 3'd4
	} reg_index_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  repeat_count;
		logic [15:0] on_time;
		logic [15:0] off_time;
	} req_t;

	typedef struct packed {
		logic [7:0]           led_red;
		logic [7:0]           led_green;
		logic [7:0]           led_blue;
		logic                 accepted;
		logic [PENDING_W-1:0] pending;
	} res_t;

	// One queued command. The blink flag is not kept: only the off time and
	// repeat count decide how a command runs.
	typedef struct packed {
		logic [23:0] color;
		logic [15:0] on_time;
		logic [15:0] off_time;
		logic [7:0]  repeats;
	} entry_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_ON   = 3'b010,
		PH_OFF  = 3'b100
	} phase_t;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_PUSH  = 7'b0000010,
		ST_TICK  = 7'b0000100,
		ST_READ  = 7'b0001000,
		ST_LOAD  = 7'b0010000,
		ST_CLEAR = 7'b0100000,
		ST_OUT   = 7'b1000000
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic push;
		logic tick;
		logic read;
		logic load;
		logic clear;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic pop_needed;
	} dp_status_t;

	// v * b / 255 without a divider. The estimate (x + x/256) / 256 is never
	// above the true quotient and at most one below it, so one compare and
	// increment finishes the job.
	function automatic logic [7:0] scale_channel(input logic [7:0] v, input logic [7:0] b);
		logic [15:0] x;
		logic [15:0] rem;
		logic [7:0]  q;
		x   = {8'd0, v} * {8'd0, b};
		q   = 8'((x + (x >> 8)) >> 8);
		rem = x - ({q, 8'd0} - {8'd0, q});
		if (rem >= 16'd255) begin
			q = q + 8'd1;
		end
		return q;
	endfunction

endpackage

FILE: rtl/core/lbps_ram.sv
// ----------------------------------------------------------------------------
// lbps_ram: generic single write port, single read port RAM
// Synchronous write, registered read data.
// ----------------------------------------------------------------------------
module lbps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/lbps_ctrl.sv
// ----------------------------------------------------------------------------
// lbps_ctrl: sequencing controller
// Walks each command through push, tick, queue read and load, clear and
// result steps, and drives the result strobe.
// ----------------------------------------------------------------------------
module lbps_ctrl import lbps_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  cmd_t       cmd,
	input  dp_status_t status,
	output logic       busy,
	output logic       done,
	output dp_cmd_t    dp_cmd
);

	ctrl_state_t state_q, state_d;
	logic        done_q;
	logic        accept;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (cmd)
						CMD_TICK: state_d = ST_TICK;
						CMD_OFF:  state_d = ST_CLEAR;
						default:  state_d = ST_PUSH;
					endcase
				end
			end
			ST_PUSH:  state_d = ST_OUT;
			ST_CLEAR: state_d = ST_OUT;
			ST_TICK:  state_d = ST_READ;
			ST_READ:  state_d = status.pop_needed ? ST_LOAD : ST_OUT;
			ST_LOAD:  state_d = ST_OUT;
			ST_OUT:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		dp_cmd.capture = accept;
		dp_cmd.push    = (state_q == ST_PUSH);
		dp_cmd.tick    = (state_q == ST_TICK);
		dp_cmd.read    = (state_q == ST_READ);
		dp_cmd.load    = (state_q == ST_LOAD);
		dp_cmd.clear   = (state_q == ST_CLEAR);
		dp_cmd.emit    = (state_q == ST_OUT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_OUT);
		end
	end

endmodule

FILE: rtl/core/lbps_datapath.sv
// ----------------------------------------------------------------------------
// lbps_datapath: queue, phase timers, heartbeat and output scaling
// Holds the configuration registers, the command queue memory with its head
// and count, the running command and the result register.
// ----------------------------------------------------------------------------
module lbps_datapath import lbps_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  req_t                 request,
	input  dp_cmd_t              dp_cmd,
	output dp_status_t           status,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output res_t                 result
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = CW + 1;
	localparam logic [CW-1:0] CNT_ONE  = CW'(1);
	localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);
	localparam logic [AW-1:0] HEAD_ONE = AW'(1);
	localparam logic [AW-1:0] HEAD_TOP = AW'(QUEUE_DEPTH - 1);
	localparam logic [SW-1:0] SUM_WRAP = SW'(QUEUE_DEPTH);

	// Configuration registers.
	logic [7:0]  brightness_q;
	logic [15:0] hb_on_time_q;
	logic [15:0] hb_off_time_q;
	logic [23:0] hb_period_q;
	logic        color_mode_q;

	// Sequencer state.
	req_t        item_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	phase_t      phase_q;
	logic [15:0] phase_timer_q;
	logic [7:0]  repeats_q;
	logic [23:0] active_color_q;
	logic [15:0] active_on_q;
	logic [15:0] active_off_q;
	logic [23:0] hb_timer_q;
	logic        accepted_q;
	res_t        result_q;

	// Queue memory port.
	logic        mem_we;
	logic [AW-1:0] mem_waddr;
	entry_t      mem_wdata;
	entry_t      mem_rdata;

	// Push path, shared by requests and the heartbeat.
	logic          req_valid;
	logic          full;
	logic [SW-1:0] tail_sum;
	logic [AW-1:0] tail_slot;
	logic [AW-1:0] head_inc;
	entry_t        req_entry;
	entry_t        hb_entry;

	// Tick path.
	logic [23:0] hb_period_eff;
	logic [23:0] hb_inc;
	logic        hb_fire;
	logic        hb_push;
	phase_t      phase_d;
	logic [15:0] timer_d;
	logic [7:0]  repeats_d;
	logic [15:0] timer_dec;
	logic [7:0]  repeats_dec;
	logic [15:0] on_start;
	logic [7:0]  pop_repeats;

	assign req_valid = (item_q.cmd == CMD_PULSE) ||
		((item_q.cmd == CMD_BLINK) && (item_q.repeat_count != 8'd0));
	assign full      = (count_q == CNT_FULL);
	assign tail_sum  = SW'(head_q) + SW'(count_q);
	assign tail_slot = (tail_sum >= SUM_WRAP) ? AW'(tail_sum - SUM_WRAP) : AW'(tail_sum);
	assign head_inc  = (head_q == HEAD_TOP) ? '0 : head_q + HEAD_ONE;

	always_comb begin
		req_entry.color    = {item_q.red, item_q.green, item_q.blue};
		req_entry.on_time  = item_q.on_time;
		if (item_q.cmd == CMD_BLINK) begin
			req_entry.off_time = item_q.off_time;
			req_entry.repeats  = item_q.repeat_count;
		end else begin
			req_entry.off_time = 16'd0;
			req_entry.repeats  = 8'd1;
		end
		hb_entry.color    = color_mode_q ? HB_COLOR_DEVICES : HB_COLOR_MEDIA;
		hb_entry.on_time  = hb_on_time_q;
		hb_entry.off_time = hb_off_time_q;
		hb_entry.repeats  = 8'd1;
	end

	// A heartbeat is only queued into an empty queue, so it lands at the head.
	assign hb_period_eff = (hb_period_q == 24'd0) ? 24'd1 : hb_period_q;
	assign hb_inc        = hb_timer_q + 24'd1;
	assign hb_fire       = (hb_inc >= hb_period_eff) || (hb_inc == 24'd0);
	assign hb_push       = dp_cmd.tick && hb_fire && (count_q == '0);

	assign mem_we    = (dp_cmd.push && req_valid) || hb_push;
	assign mem_waddr = full ? head_q : tail_slot;
	assign mem_wdata = dp_cmd.push ? req_entry : hb_entry;

	lbps_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (dp_cmd.read),
		.raddr (head_q),
		.rdata (mem_rdata)
	);

	// Phase advance on a tick.
	assign timer_dec   = (phase_timer_q != 16'd0) ? phase_timer_q - 16'd1 : 16'd0;
	assign repeats_dec = (repeats_q != 8'd0) ? repeats_q - 8'd1 : 8'd0;
	assign on_start    = (active_on_q == 16'd0) ? 16'd1 : active_on_q;

	always_comb begin
		phase_d   = phase_q;
		timer_d   = phase_timer_q;
		repeats_d = repeats_q;
		case (phase_q)
			PH_ON: begin
				timer_d = timer_dec;
				if (timer_dec == 16'd0) begin
					if (active_off_q != 16'd0) begin
						phase_d = PH_OFF;
						timer_d = active_off_q;
					end else begin
						repeats_d = repeats_dec;
						phase_d   = (repeats_dec != 8'd0) ? PH_ON : PH_IDLE;
						timer_d   = (repeats_dec != 8'd0) ? on_start : 16'd0;
					end
				end
			end
			PH_OFF: begin
				timer_d = timer_dec;
				if (timer_dec == 16'd0) begin
					repeats_d = repeats_dec;
					phase_d   = (repeats_dec != 8'd0) ? PH_ON : PH_IDLE;
					timer_d   = (repeats_dec != 8'd0) ? on_start : 16'd0;
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	assign status.pop_needed = (phase_q == PH_IDLE) && (count_q != '0);
	assign pop_repeats       = (mem_rdata.repeats == 8'd0) ? 8'd1 : mem_rdata.repeats;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q  <= BRIGHTNESS_RST;
			hb_on_time_q  <= HB_ON_TIME_RST;
			hb_off_time_q <= HB_OFF_TIME_RST;
			hb_period_q   <= HB_PERIOD_RST;
			color_mode_q  <= COLOR_MODE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BRIGHTNESS:  brightness_q  <= cfg_data[7:0];
				REG_HB_ON_TIME:  hb_on_time_q  <= cfg_data[15:0];
				REG_HB_OFF_TIME: hb_off_time_q <= cfg_data[15:0];
				REG_HB_PERIOD:   hb_period_q   <= cfg_data[23:0];
				REG_COLOR_MODE:  color_mode_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q         <= '0;
			count_q        <= '0;
			phase_q        <= PH_IDLE;
			phase_timer_q  <= 16'd0;
			repeats_q      <= 8'd0;
			active_color_q <= 24'd0;
			active_on_q    <= 16'd0;
			active_off_q   <= 16'd0;
			hb_timer_q     <= 24'd0;
			accepted_q     <= 1'b0;
		end else begin
			if (dp_cmd.capture) begin
				accepted_q <= 1'b0;
			end
			if (dp_cmd.push && req_valid) begin
				accepted_q <= 1'b1;
				if (full) begin
					head_q <= head_inc;
				end else begin
					count_q <= count_q + CNT_ONE;
				end
			end
			if (dp_cmd.tick) begin
				hb_timer_q    <= hb_fire ? 24'd0 : hb_inc;
				phase_q       <= phase_d;
				phase_timer_q <= timer_d;
				repeats_q     <= repeats_d;
				if (hb_push) begin
					count_q <= CNT_ONE;
				end
			end
			if (dp_cmd.load) begin
				active_color_q <= mem_rdata.color;
				active_on_q    <= mem_rdata.on_time;
				active_off_q   <= mem_rdata.off_time;
				repeats_q      <= pop_repeats;
				phase_q        <= PH_ON;
				phase_timer_q  <= (mem_rdata.on_time == 16'd0) ? 16'd1 : mem_rdata.on_time;
				head_q         <= head_inc;
				count_q        <= count_q - CNT_ONE;
			end
			if (dp_cmd.clear) begin
				head_q        <= '0;
				count_q       <= '0;
				phase_q       <= PH_IDLE;
				phase_timer_q <= 16'd0;
				repeats_q     <= 8'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.capture) begin
			item_q <= request;
		end
		if (dp_cmd.emit) begin
			if (phase_q == PH_ON) begin
				result_q.led_red   <= scale_channel(active_color_q[23:16], brightness_q);
				result_q.led_green <= scale_channel(active_color_q[15:8], brightness_q);
				result_q.led_blue  <= scale_channel(active_color_q[7:0], brightness_q);
			end else begin
				result_q.led_red   <= 8'd0;
				result_q.led_green <= 8'd0;
				result_q.led_blue  <= 8'd0;
			end
			result_q.accepted <= accepted_q;
			result_q.pending  <= PENDING_W'(count_q);
		end
	end

	assign result = result_q;

endmodule

FILE: rtl/core/led_blink_pulse_sequencer.sv
// ----------------------------------------------------------------------------
// led_blink_pulse_sequencer: RGB LED pulse and blink sequencer
// Queues pulse and blink requests, plays them out on one-millisecond ticks,
// adds a heartbeat pulse while the queue is empty and scales the shown color.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                          Handshake
//  --------  -------------------------------  ---------------------------------
//  request   start, busy, request             beat taken when start && !busy
//  result    done, result                     beat valid for the one done cycle
//  config    cfg_we, cfg_index, cfg_data      write taken when cfg_we is high
//
// Every input beat produces exactly one result beat. Pulse and blink run the
// push step, all-off the clear step, and then the output step loads the
// result register and done is registered from it. A tick runs the tick and
// queue read steps, and the load step when it starts a queued command, since
// the queue memory has a registered read and the head entry is fetched in a
// step of its own. Busy stays high from the taking edge until the result
// cycle, so one command is in flight at a time. Reset clears the controller,
// the queue pointers, the phase timers and loads the register defaults; the
// queue memory needs no clearing because only counted entries are ever read.
// The result side cannot stall: the result is shown for one cycle only.
//
// Configuration writes are meant for idle periods between commands.
// ----------------------------------------------------------------------------
module led_blink_pulse_sequencer import lbps_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  req_t                 request,
	output logic                 done,
	output res_t                 result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	// Commands from the controller to the datapath and status coming back.
	dp_cmd_t    dp_cmd;
	dp_status_t dp_status;

	// The controller decides the step sequence from the command code alone;
	// the only status it needs is whether a tick left the sequencer idle with
	// work waiting in the queue.
	lbps_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (request.cmd),
		.status (dp_status),
		.busy   (busy),
		.done   (done),
		.dp_cmd (dp_cmd)
	);

	// The datapath owns all architectural state, including the configuration
	// registers and the result register that is loaded in the output step.
	lbps_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.request   (request),
		.dp_cmd    (dp_cmd),
		.status    (dp_status),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result)
	);

endmodule

FILE: rtl/core/lbps_checker.sv
// ----------------------------------------------------------------------------
// lbps_checker: port-level checks of the LED sequencer
// Watches the request and result handshakes over time.
// ----------------------------------------------------------------------------
module lbps_checker import lbps_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input res_t result
);

	// A taken beat keeps the block busy in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n) start && !busy |=> busy)
		else $error("busy did not rise after a request beat");

	// No result comes out in the cycle right after a request beat.
	assert property (@(posedge clk) disable iff (!arst_n) start && !busy |=> !done)
		else $error("result strobe too early after a request beat");

	// Every result beat ends a busy period.
	assert property (@(posedge clk) disable iff (!arst_n) done |-> $past(busy))
		else $error("result strobe without a command in flight");

	// A result beat lasts one cycle only.
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result strobe held longer than one cycle");

	// A result beat carries fully defined values.
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !$isunknown(result))
		else $error("result beat carries unknown bits");

endmodule

bind led_blink_pulse_sequencer lbps_checker u_lbps_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
